FILE: src/dlps_pkg.sv
`default_nettype none
package dlps_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int FRAC_BITS = 16;
	localparam int STEP_BITS = 18;
	localparam int STORE_DEPTH_DEF = 480;
	localparam logic [STEP_BITS-1:0] STEP_RESET = 18'd65536;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_in;
		logic signed [SAMPLE_BITS-1:0] right_in;
		logic                          frame_last;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_out;
		logic signed [SAMPLE_BITS-1:0] right_out;
		logic                          frame_last_out;
	} out_item_t;

endpackage
`default_nettype wire

FILE: src/delay_line_pitch_shift_unit.sv
// Stereo delay-line pitch shifter with linear interpolation.
// Input samples arrive on the src channel (valid/ready); each transfer writes
// the pair into a circular store and reads two neighboring entries at the
// fractional read position, which advances by read_step (unsigned Q2.16).
// The interpolated pair leaves on the dst channel (valid/ready), one result
// per input, in order, with frame_last copied through.
// An input transfer is registered in the store read registers, then the lane products, then the output register.
// Throughput: one item per cycle while dst accepts, set by the three-stage pipeline around a
// store with one write port and two registered read ports.
// cfg_we writes read_step in the same cycle; write it only while idle.
// After reset the read position and write index are zero, read_step is 1.0,
// and every store entry reads as zero until written; no clearing pass runs.
// When dst stalls, the output register holds its result and the pipeline keeps
// accepting until its stages are full, then src_ready drops.
`default_nettype none
module delay_line_pitch_shift_unit #(
	parameter int STORE_DEPTH = dlps_pkg::STORE_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               src_valid,
	output logic                                    src_ready,
	input  wire dlps_pkg::in_item_t                 src_item,
	output logic                                    dst_valid,
	input  wire logic                               dst_ready,
	output dlps_pkg::out_item_t                     dst_item,
	input  wire logic                               cfg_we,
	input  wire logic [dlps_pkg::STEP_BITS-1:0]     cfg_wdata
);

	localparam int IDX_W = $clog2(STORE_DEPTH);
	localparam int FB = dlps_pkg::FRAC_BITS;
	localparam int SB = dlps_pkg::SAMPLE_BITS;
	localparam int POS_W = IDX_W + FB;

	logic [dlps_pkg::STEP_BITS-1:0] step_q;
	logic [POS_W-1:0]               rd_pos_q;
	logic [IDX_W-1:0]               wr_idx_q;
	logic [POS_W:0]                 pos_sum;
	logic [IDX_W-1:0]               rd_idx;
	logic [IDX_W-1:0]               rd_nxt;
	logic                           accept;
	logic                           en1;
	logic                           en2;
	logic                           en3;
	logic                           v_s1;
	logic                           v_s2;
	logic [FB-1:0]                  frac_s1;
	logic                           last_s1;
	logic                           last_s2;
	logic [2*SB-1:0]                data_a;
	logic [2*SB-1:0]                data_b;
	logic                           ok_a;
	logic                           ok_b;
	logic signed [SB-1:0]           left_mix;
	logic signed [SB-1:0]           right_mix;

	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign src_ready = en1;
	assign accept = src_valid && en1;

	assign rd_idx = rd_pos_q[POS_W-1:FB];
	assign rd_nxt = (rd_idx == IDX_W'(STORE_DEPTH - 1)) ? '0 : rd_idx + 1'b1;
	assign pos_sum = {1'b0, rd_pos_q} + (POS_W+1)'(step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= dlps_pkg::STEP_RESET;
			rd_pos_q <= '0;
			wr_idx_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (cfg_we) begin
				step_q <= cfg_wdata;
			end
			if (accept) begin
				if (pos_sum[POS_W:FB] >= (IDX_W+1)'(STORE_DEPTH)) begin
					rd_pos_q <= POS_W'(pos_sum - {(IDX_W+1)'(STORE_DEPTH), FB'(0)});
				end else begin
					rd_pos_q <= POS_W'(pos_sum);
				end
				wr_idx_q <= (wr_idx_q == IDX_W'(STORE_DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
			end
			if (en1) begin
				v_s1 <= accept;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			frac_s1 <= rd_pos_q[FB-1:0];
			last_s1 <= src_item.frame_last;
		end
		if (en2) begin
			last_s2 <= last_s1;
		end
	end

	dlps_store #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.access(accept),
		.wr_addr(wr_idx_q),
		.wr_data({src_item.left_in, src_item.right_in}),
		.rd_addr_a(rd_idx),
		.rd_addr_b(rd_nxt),
		.rd_data_a(data_a),
		.rd_data_b(data_b),
		.rd_ok_a(ok_a),
		.rd_ok_b(ok_b)
	);

	dlps_lane u_lane_left (
		.clk(clk),
		.en(en2),
		.a(data_a[2*SB-1:SB]),
		.b(data_b[2*SB-1:SB]),
		.a_ok(ok_a),
		.b_ok(ok_b),
		.frac(frac_s1),
		.mix(left_mix)
	);

	dlps_lane u_lane_right (
		.clk(clk),
		.en(en2),
		.a(data_a[SB-1:0]),
		.b(data_b[SB-1:0]),
		.a_ok(ok_a),
		.b_ok(ok_b),
		.frac(frac_s1),
		.mix(right_mix)
	);

	dlps_merge u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.valid_s2(v_s2),
		.left_mix(left_mix),
		.right_mix(right_mix),
		.last_s2(last_s2),
		.dst_ready(dst_ready),
		.dst_valid(dst_valid),
		.dst_item(dst_item),
		.advance(en3)
	);

endmodule
`default_nettype wire

FILE: src/dlps_store.sv
`default_nettype none
module dlps_store #(
	parameter int STORE_DEPTH = dlps_pkg::STORE_DEPTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  access,
	input  wire logic [$clog2(STORE_DEPTH)-1:0]        wr_addr,
	input  wire logic [2*dlps_pkg::SAMPLE_BITS-1:0]    wr_data,
	input  wire logic [$clog2(STORE_DEPTH)-1:0]        rd_addr_a,
	input  wire logic [$clog2(STORE_DEPTH)-1:0]        rd_addr_b,
	output logic      [2*dlps_pkg::SAMPLE_BITS-1:0]    rd_data_a,
	output logic      [2*dlps_pkg::SAMPLE_BITS-1:0]    rd_data_b,
	output logic                                       rd_ok_a,
	output logic                                       rd_ok_b
);

	localparam int IDX_W = $clog2(STORE_DEPTH);
	localparam int WORD_W = 2 * dlps_pkg::SAMPLE_BITS;

	logic [WORD_W-1:0] mem [STORE_DEPTH];
	logic              full_q;

	// An entry holds written data once the write index has passed it or the
	// store has wrapped once; otherwise its rd_ok flag is low and the lane reads it as zero.
	always_ff @(posedge clk) begin
		if (access) begin
			mem[wr_addr] <= wr_data;
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			rd_ok_a <= 1'b0;
			rd_ok_b <= 1'b0;
		end else if (access) begin
			if (wr_addr == IDX_W'(STORE_DEPTH - 1)) begin
				full_q <= 1'b1;
			end
			rd_ok_a <= full_q || (rd_addr_a < wr_addr);
			rd_ok_b <= full_q || (rd_addr_b < wr_addr);
		end
	end

endmodule
`default_nettype wire

FILE: src/dlps_lane.sv
`default_nettype none
module dlps_lane (
	input  wire logic                                         clk,
	input  wire logic                                         en,
	input  wire logic signed [dlps_pkg::SAMPLE_BITS-1:0]      a,
	input  wire logic signed [dlps_pkg::SAMPLE_BITS-1:0]      b,
	input  wire logic                                         a_ok,
	input  wire logic                                         b_ok,
	input  wire logic        [dlps_pkg::FRAC_BITS-1:0]        frac,
	output logic signed      [dlps_pkg::SAMPLE_BITS-1:0]      mix
);

	localparam int SB = dlps_pkg::SAMPLE_BITS;
	localparam int FB = dlps_pkg::FRAC_BITS;
	localparam int PW = SB + FB + 2;

	logic signed [SB-1:0] a_eff;
	logic signed [SB-1:0] b_eff;
	logic        [FB:0]   wa;
	logic signed [PW-1:0] prod_a_s2;
	logic signed [PW-1:0] prod_b_s2;
	logic signed [PW:0]   sum;

	assign a_eff = a_ok ? a : '0;
	assign b_eff = b_ok ? b : '0;
	assign wa = (FB+1)'(1 << FB) - {1'b0, frac};

	always_ff @(posedge clk) begin
		if (en) begin
			prod_a_s2 <= PW'(a_eff * $signed({1'b0, wa}));
			prod_b_s2 <= PW'(b_eff * $signed({2'b00, frac}));
		end
	end

	// The weights add up to one, so the rounded mix stays in sample range.
	assign sum = (PW+1)'(prod_a_s2) + (PW+1)'(prod_b_s2) + (PW+1)'(1 << (FB - 1));
	assign mix = sum[SB+FB-1:FB];

endmodule
`default_nettype wire

FILE: src/dlps_merge.sv
`default_nettype none
module dlps_merge (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     valid_s2,
	input  wire logic signed [dlps_pkg::SAMPLE_BITS-1:0]  left_mix,
	input  wire logic signed [dlps_pkg::SAMPLE_BITS-1:0]  right_mix,
	input  wire logic                                     last_s2,
	input  wire logic                                     dst_ready,
	output logic                                          dst_valid,
	output dlps_pkg::out_item_t                           dst_item,
	output logic                                          advance
);

	logic                valid_q;
	dlps_pkg::out_item_t item_q;

	assign advance = !valid_q || dst_ready;
	assign dst_valid = valid_q;
	assign dst_item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			item_q.left_out <= left_mix;
			item_q.right_out <= right_mix;
			item_q.frame_last_out <= last_s2;
		end
	end

endmodule
`default_nettype wire

FILE: tb/delay_line_pitch_shift_unit_test.sv
`timescale 1ns / 100ps
module delay_line_pitch_shift_unit_test;

	localparam int SAMPLE_BITS = dlps_pkg::SAMPLE_BITS;
	localparam int FRAC_BITS = dlps_pkg::FRAC_BITS;
	localparam int STEP_BITS = dlps_pkg::STEP_BITS;
	localparam int DEPTH = dlps_pkg::STORE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 200000;

	typedef dlps_pkg::in_item_t in_item_t;
	typedef dlps_pkg::out_item_t out_item_t;

	class stereo_mix_board;
		logic signed [SAMPLE_BITS-1:0] left_line[DEPTH];
		logic signed [SAMPLE_BITS-1:0] right_line[DEPTH];
		int unsigned wr_slot;
		int unsigned rd_pos;
		logic [STEP_BITS-1:0] step;
		out_item_t expected_frames[$];
		int unsigned errors;
		int unsigned checked;

		function new();
			foreach (left_line[i]) begin
				left_line[i] = '0;
				right_line[i] = '0;
			end
			wr_slot = 0;
			rd_pos = 0;
			step = dlps_pkg::STEP_RESET;
			errors = 0;
			checked = 0;
		endfunction

		function void set_step(logic [STEP_BITS-1:0] value);
			step = value;
		endfunction

		function int pending();
			return expected_frames.size();
		endfunction

		function logic signed [SAMPLE_BITS-1:0] blend(logic signed [SAMPLE_BITS-1:0] a,
				logic signed [SAMPLE_BITS-1:0] b, int unsigned frac);
			longint wa;
			longint wb;
			longint acc;
			wb = longint'(frac);
			wa = 64'sd65536 - wb;
			acc = longint'(a) * wa + longint'(b) * wb + 64'sd32768;
			acc = acc >>> FRAC_BITS;
			return acc[SAMPLE_BITS-1:0];
		endfunction

		function void note_sample(in_item_t s);
			int unsigned idx;
			int unsigned nxt;
			int unsigned frac;
			out_item_t e;
			idx = rd_pos >> FRAC_BITS;
			frac = rd_pos & 32'hFFFF;
			if (idx >= DEPTH) begin
				idx = 0;
			end
			nxt = (idx + 1 >= DEPTH) ? 0 : idx + 1;
			e.left_out = blend(left_line[idx], left_line[nxt], frac);
			e.right_out = blend(right_line[idx], right_line[nxt], frac);
			e.frame_last_out = s.frame_last;
			expected_frames.push_back(e);
			left_line[wr_slot] = s.left_in;
			right_line[wr_slot] = s.right_in;
			rd_pos += step;
			if ((rd_pos >> FRAC_BITS) >= DEPTH) begin
				rd_pos -= DEPTH << FRAC_BITS;
			end
			wr_slot = (wr_slot + 1 >= DEPTH) ? 0 : wr_slot + 1;
		endfunction

		task report(string what);
			$display("MISMATCH: %s", what);
			errors++;
		endtask

		task check_frame(out_item_t got);
			out_item_t e;
			if (expected_frames.size() == 0) begin
				report($sformatf("unexpected result transfer %p", got));
			end else begin
				e = expected_frames.pop_front();
				checked++;
				if (got.left_out !== e.left_out) begin
					report($sformatf("result %0d left_out %0d, expected %0d",
						checked, got.left_out, e.left_out));
				end
				if (got.right_out !== e.right_out) begin
					report($sformatf("result %0d right_out %0d, expected %0d",
						checked, got.right_out, e.right_out));
				end
				if (got.frame_last_out !== e.frame_last_out) begin
					report($sformatf("result %0d frame_last_out %b, expected %b",
						checked, got.frame_last_out, e.frame_last_out));
				end
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic src_valid;
	logic src_ready;
	in_item_t src_item;
	logic dst_valid;
	logic dst_ready;
	out_item_t dst_item;
	logic cfg_we;
	logic [STEP_BITS-1:0] cfg_wdata;

	stereo_mix_board board;
	int src_idle_pct;
	int dst_idle_pct;
	int cycle_count;
	int samples_sent;
	int step_writes;

	delay_line_pitch_shift_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_item(src_item),
		.dst_valid(dst_valid),
		.dst_ready(dst_ready),
		.dst_item(dst_item),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && dst_valid && dst_ready) begin
			board.check_frame(dst_item);
		end
		dst_ready <= ($urandom_range(99) >= dst_idle_pct);
	end

	function in_item_t make_sample(logic [SAMPLE_BITS-1:0] l, logic [SAMPLE_BITS-1:0] r,
			logic fl);
		in_item_t s;
		s.left_in = l;
		s.right_in = r;
		s.frame_last = fl;
		return s;
	endfunction

	function logic [SAMPLE_BITS-1:0] rand_level();
		if ($urandom_range(7) != 0) begin
			return SAMPLE_BITS'($urandom);
		end
		case ($urandom_range(3))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'h000000;
			default: return 24'hFFFFFF;
		endcase
	endfunction

	function in_item_t rand_sample();
		return make_sample(rand_level(), rand_level(), 1'($urandom_range(1)));
	endfunction

	task automatic push_sample(in_item_t s);
		while ($urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_item <= s;
		do @(posedge clk); while (!src_ready);
		board.note_sample(s);
		samples_sent++;
	endtask

	task automatic drain();
		src_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_read_step(logic [STEP_BITS-1:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_step(value);
		step_writes++;
	endtask

	initial begin
		arst_n = 1'b0;
		src_valid = 1'b0;
		src_item = '0;
		dst_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cycle_count = 0;
		samples_sent = 0;
		step_writes = 0;
		src_idle_pct = 21;
		dst_idle_pct = 88;
		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_sample(make_sample(24'h7FFFFF, 24'h800000, 1'b1));
		push_sample(make_sample(24'h800000, 24'h7FFFFF, 1'b0));
		push_sample(make_sample(24'h000000, 24'h000000, 1'b1));
		push_sample(make_sample(24'hFFFFFF, 24'hFFFFFF, 1'b0));
		push_sample(make_sample(24'h555555, 24'hAAAAAA, 1'b1));
		push_sample(make_sample(24'hAAAAAA, 24'h555555, 1'b0));
		set_read_step(18'd32768);
		repeat (4) push_sample(rand_sample());
		set_read_step('0);
		repeat (3) push_sample(rand_sample());
		set_read_step(18'h3FFFF);
		repeat (4) push_sample(rand_sample());
		set_read_step(18'd131072);
		repeat (3) push_sample(rand_sample());

		for (int batch = 0; batch < 10; batch++) begin
			if (batch == 3) begin
				src_idle_pct = 88;
				dst_idle_pct = 21;
			end
			if (batch == 6) begin
				src_idle_pct = 0;
				dst_idle_pct = 0;
			end
			case (batch % 4)
				0: set_read_step(18'h3FFFF);
				1: set_read_step(STEP_BITS'($urandom_range(131072, 32768)));
				2: begin
					case ($urandom_range(2))
						0: set_read_step('0);
						1: set_read_step(18'd32768);
						default: set_read_step(18'd131072);
					endcase
				end
				default: set_read_step(STEP_BITS'($urandom_range(18'h3FFFF, 0)));
			endcase
			repeat (38) push_sample(rand_sample());
		end

		drain();
		repeat (6) @(posedge clk);
		$display("Sent %0d stereo samples under %0d read-step writes, including frozen,",
			samples_sent, step_writes);
		$display("half-speed, double-speed and near-4x steps; %0d results compared.",
			board.checked);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
